### rtl/masu_pkg.sv
// Shared types, constants and a helper function for the multichannel ADC sample unpacker.
// Used by masu_regs, masu_unpack, the top level and the checker; depends on nothing.
package masu_pkg;

  // Channel layout: groups of channels, each group padded to a byte boundary.
  localparam int GROUP_COUNT        = 4;
  localparam int CHANNELS_PER_GROUP = 8;
  localparam int TRIGGER_CHANNELS   = 8;
  localparam int SLOT_TOTAL         = GROUP_COUNT * CHANNELS_PER_GROUP;
  localparam int SLOT_W             = $clog2(SLOT_TOTAL + 1);
  localparam int COMP_MAX           = 63;

  // Block length limits in bytes.
  localparam int PAD_MIN = 1;
  localparam int PAD_MAX = 64;
  localparam int BYTE_CNT_W = 7;

  // Configuration port geometry: seven registers at 8-byte spacing.
  localparam int REG_COUNT  = 7;
  localparam int CFG_DATA_W = 64;
  localparam int CFG_ADDR_W = $clog2(8 * REG_COUNT);

  // Register indexes.
  typedef enum logic [2:0] {
    REG_WIDTH_MODE = 3'd0,
    REG_ENABLED    = 3'd1,
    REG_PADDED     = 3'd2,
    REG_TRIG_ARMED = 3'd3,
    REG_TRIG_MODES = 3'd4,
    REG_LEVELS_LO  = 3'd5,
    REG_LEVELS_HI  = 3'd6
  } reg_idx_t;

  // Sample width codes; the unused code behaves as 14 bits.
  localparam logic [1:0] WMODE_8  = 2'd0;
  localparam logic [1:0] WMODE_12 = 2'd1;
  localparam logic [1:0] WMODE_14 = 2'd2;

  // Trigger mode codes; the unused code behaves as below-level.
  localparam logic [1:0] TRIG_OFF   = 2'd0;
  localparam logic [1:0] TRIG_ABOVE = 2'd1;
  localparam logic [1:0] TRIG_BELOW = 2'd2;

  typedef logic [SLOT_W-1:0]     slot_t;
  typedef logic [SLOT_TOTAL-1:0] slot_vec_t;

  // Configuration as seen by the datapath.
  typedef struct packed {
    logic [1:0]  width_mode;
    logic [31:0] enabled;
    logic [6:0]  padded;
    logic        armed;
    logic [15:0] modes;
    logic [63:0] levels_lo;
    logic [63:0] levels_hi;
  } cfg_t;

  // One unpacked sample.
  typedef struct packed {
    logic [13:0] sample_value;
    logic [4:0]  physical_channel;
    logic [4:0]  active_channel;
    logic        trigger_hit;
    logic [31:0] block_number;
    logic        last_in_block;
  } result_t;

  // Index of the lowest set bit, or SLOT_TOTAL when no bit is set.
  function automatic slot_t find_first(input slot_vec_t v);
    slot_t idx;
    idx = slot_t'(SLOT_TOTAL);
    for (int i = SLOT_TOTAL - 1; i >= 0; i--) begin
      if (v[i]) begin
        idx = slot_t'(i);
      end
    end
    return idx;
  endfunction

endpackage

### rtl/masu_regs.sv
// APB-style configuration register file of the sample unpacker.
// Depends on masu_pkg for register indexes, reset values and the cfg_t struct.
module masu_regs (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [masu_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [masu_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [masu_pkg::CFG_DATA_W-1:0] prdata,
  output logic                            pready,
  output masu_pkg::cfg_t                  cfg
);
  import masu_pkg::*;

  logic [1:0]  width_mode_r;
  logic [31:0] enabled_r;
  logic [6:0]  padded_r;
  logic        armed_r;
  logic [15:0] modes_r;
  logic [63:0] levels_lo_r;
  logic [63:0] levels_hi_r;
  logic        wr_en;
  reg_idx_t    idx;

  // Registers sit at 8-byte spacing; the low address bits are ignored.
  assign idx    = reg_idx_t'(paddr[CFG_ADDR_W-1:3]);
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;

  // Register writes complete in the access phase.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_mode_r <= WMODE_14;
      enabled_r    <= 32'hFFFF_FFFF;
      padded_r     <= 7'd56;
      armed_r      <= 1'b0;
      modes_r      <= 16'h0000;
      levels_lo_r  <= 64'h0;
      levels_hi_r  <= 64'h0;
    end else if (wr_en) begin
      unique case (idx)
        REG_WIDTH_MODE: width_mode_r <= pwdata[1:0];
        REG_ENABLED:    enabled_r    <= pwdata[31:0];
        REG_PADDED:     padded_r     <= pwdata[6:0];
        REG_TRIG_ARMED: armed_r      <= pwdata[0];
        REG_TRIG_MODES: modes_r      <= pwdata[15:0];
        REG_LEVELS_LO:  levels_lo_r  <= pwdata;
        REG_LEVELS_HI:  levels_hi_r  <= pwdata;
        default: ;
      endcase
    end
  end

  // Read-back multiplexer.
  always_comb begin
    unique case (idx)
      REG_WIDTH_MODE: prdata = CFG_DATA_W'(width_mode_r);
      REG_ENABLED:    prdata = CFG_DATA_W'(enabled_r);
      REG_PADDED:     prdata = CFG_DATA_W'(padded_r);
      REG_TRIG_ARMED: prdata = CFG_DATA_W'(armed_r);
      REG_TRIG_MODES: prdata = CFG_DATA_W'(modes_r);
      REG_LEVELS_LO:  prdata = levels_lo_r;
      REG_LEVELS_HI:  prdata = levels_hi_r;
      default:        prdata = '0;
    endcase
  end

  assign cfg.width_mode = width_mode_r;
  assign cfg.enabled    = enabled_r;
  assign cfg.padded     = padded_r;
  assign cfg.armed      = armed_r;
  assign cfg.modes      = modes_r;
  assign cfg.levels_lo  = levels_lo_r;
  assign cfg.levels_hi  = levels_hi_r;

endmodule

### rtl/masu_unpack.sv
// Unpacking state and single-pass datapath: bit accumulator, slot search, trigger compare.
// Depends on masu_pkg for the channel layout, cfg_t, result_t and find_first.
module masu_unpack (
  input  logic              clk,
  input  logic              rst_n,
  input  masu_pkg::cfg_t    cfg,
  input  logic              word_fire,
  input  logic [7:0]        payload_byte,
  output logic              emit,
  output masu_pkg::result_t result
);
  import masu_pkg::*;

  logic [23:0]           acc_r, acc_nxt;
  logic [4:0]            held_r, held_nxt;
  slot_t                 slot_r, slot_nxt;
  logic [5:0]            comp_r, comp_nxt;
  logic [BYTE_CNT_W-1:0] count_r, count_nxt;
  logic [31:0]           blocks_r, blocks_nxt;

  slot_vec_t             slot_en;
  slot_vec_t             above;
  slot_vec_t             rest;
  slot_t                 slot0;
  slot_t                 nxt;
  logic                  has_slot;
  logic                  last;
  logic                  grp_change;
  logic [4:0]            width;
  logic [13:0]           wmask;
  logic [4:0]            held_cap;
  logic [4:0]            held;
  logic [4:0]            shift;
  logic [23:0]           acc_new;
  logic [23:0]           shifted;
  logic [13:0]           value;
  logic [BYTE_CNT_W-1:0] pad_len;
  logic [BYTE_CNT_W-1:0] count_inc;
  logic                  trig_ok;
  logic [2:0]            trig_idx;
  logic [1:0]            trig_mode;
  logic [127:0]          levels;
  logic [15:0]           level;
  logic                  lvl_below_val;
  logic                  lvl_above_val;
  logic                  hit;

  // Sample width and value mask.
  always_comb begin
    unique case (cfg.width_mode)
      WMODE_8: begin
        width = 5'd8;
        wmask = 14'h00FF;
      end
      WMODE_12: begin
        width = 5'd12;
        wmask = 14'h0FFF;
      end
      default: begin
        width = 5'd14;
        wmask = 14'h3FFF;
      end
    endcase
  end

  // Current slot is the first enabled one at or after the stored slot;
  // the following one is the next set bit above it.
  assign slot_en  = slot_vec_t'(cfg.enabled);
  assign above    = slot_en & ({SLOT_TOTAL{1'b1}} << slot_r);
  assign rest     = above & (above - slot_vec_t'(1));
  assign slot0    = find_first(above);
  assign nxt      = find_first(rest);
  assign has_slot = (above != '0);
  assign last     = (rest == '0);
  assign grp_change = (slot0 / CHANNELS_PER_GROUP) != (nxt / CHANNELS_PER_GROUP);

  // Shift the new byte in and pick the sample out of the top held bits.
  assign held_cap = (held_r > 5'd16) ? 5'd16 : held_r;
  assign held     = held_cap + 5'd8;
  assign acc_new  = {acc_r[15:0], payload_byte};
  assign emit     = has_slot && (held >= width);
  assign shift    = held - width;
  assign shifted  = acc_new >> shift;
  assign value    = shifted[13:0] & wmask;

  // Padded block length, clamped to the legal range.
  always_comb begin
    if (cfg.padded < 7'(PAD_MIN)) begin
      pad_len = BYTE_CNT_W'(PAD_MIN);
    end else if (cfg.padded > 7'(PAD_MAX)) begin
      pad_len = BYTE_CNT_W'(PAD_MAX);
    end else begin
      pad_len = BYTE_CNT_W'(cfg.padded);
    end
  end

  assign count_inc = (count_r == {BYTE_CNT_W{1'b1}}) ? count_r : count_r + 1'b1;

  // Level trigger on the first compacted channels.
  assign trig_ok   = cfg.armed && (comp_r < 6'(TRIGGER_CHANNELS));
  assign trig_idx  = comp_r[2:0];
  assign trig_mode = cfg.modes[{trig_idx, 1'b0} +: 2];
  assign levels    = {cfg.levels_hi, cfg.levels_lo};
  assign level     = levels[{trig_idx, 4'b0000} +: 16];
  assign lvl_below_val = $signed({level[15], level}) < $signed({3'b000, value});
  assign lvl_above_val = $signed({level[15], level}) > $signed({3'b000, value});

  always_comb begin
    hit = 1'b0;
    if (trig_ok) begin
      unique case (trig_mode)
        TRIG_OFF:   hit = 1'b0;
        TRIG_ABOVE: hit = lvl_below_val;
        default:    hit = lvl_above_val;
      endcase
    end
  end

  // Result fields for the sample completed by this byte.
  assign result.sample_value     = value;
  assign result.physical_channel = slot0[4:0];
  assign result.active_channel   = comp_r[4:0];
  assign result.trigger_hit      = hit;
  assign result.block_number     = blocks_r;
  assign result.last_in_block    = last;

  // Next state for one accepted byte.
  always_comb begin
    acc_nxt    = acc_r;
    held_nxt   = held_r;
    comp_nxt   = comp_r;
    blocks_nxt = blocks_r;
    count_nxt  = count_inc;
    slot_nxt   = emit ? nxt : slot0;
    if (has_slot) begin
      acc_nxt  = acc_new;
      held_nxt = held;
    end
    if (emit) begin
      held_nxt = (last || grp_change) ? 5'd0 : shift;
      if (comp_r < 6'(COMP_MAX)) begin
        comp_nxt = comp_r + 6'd1;
      end
    end
    if (slot_nxt == slot_t'(SLOT_TOTAL)) begin
      held_nxt = 5'd0;
      // Content done and padding consumed: start the next block.
      if (count_inc >= pad_len) begin
        blocks_nxt = blocks_r + 32'd1;
        count_nxt  = '0;
        slot_nxt   = '0;
        acc_nxt    = '0;
        comp_nxt   = '0;
      end
    end
  end

  // Unpacking state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r    <= '0;
      held_r   <= '0;
      slot_r   <= '0;
      comp_r   <= '0;
      count_r  <= '0;
      blocks_r <= '0;
    end else if (word_fire) begin
      acc_r    <= acc_nxt;
      held_r   <= held_nxt;
      slot_r   <= slot_nxt;
      comp_r   <= comp_nxt;
      count_r  <= count_nxt;
      blocks_r <= blocks_nxt;
    end
  end

endmodule

### rtl/multichannel_adc_sample_unpacker_top.sv
// Output: a sample completed by an accepted byte is registered and appears on the outputs in the next cycle.
// Throughput: one payload byte per cycle; the output register frees in the same cycle
// that its sample is taken, so a byte is accepted whenever the output is not stalled.
// Reset: synchronous, active low; clears the unpacking state and the output valid and
// loads the register defaults (14-bit samples, all channels, 56-byte blocks, trigger off).
// Depends on masu_pkg, masu_regs and masu_unpack.
module multichannel_adc_sample_unpacker_top (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [7:0]                      in_payload_byte,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [13:0]                     out_sample_value,
  output logic [4:0]                      out_physical_channel,
  output logic [4:0]                      out_active_channel,
  output logic                            out_trigger_hit,
  output logic [31:0]                     out_block_number,
  output logic                            out_last_in_block,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [masu_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [masu_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [masu_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                            cfg_pready
);
  import masu_pkg::*;

  cfg_t    cfg;
  result_t result;
  result_t out_r;
  logic    out_valid_r;
  logic    emit;
  logic    word_fire;

  masu_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  // Byte handshake: stall only while a held sample is itself stalled.
  assign in_stall  = out_valid_r & out_stall;
  assign word_fire = in_valid & ~in_stall;

  masu_unpack u_unpack (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg),
    .word_fire    (word_fire),
    .payload_byte (in_payload_byte),
    .emit         (emit),
    .result       (result)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (word_fire) begin
      out_valid_r <= emit;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (word_fire && emit) begin
      out_r <= result;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_sample_value     = out_r.sample_value;
  assign out_physical_channel = out_r.physical_channel;
  assign out_active_channel   = out_r.active_channel;
  assign out_trigger_hit      = out_r.trigger_hit;
  assign out_block_number     = out_r.block_number;
  assign out_last_in_block    = out_r.last_in_block;

endmodule

### rtl/masu_checker.sv
// Port-level checker for the sample unpacker, bound to the top level.
// Depends on masu_pkg and multichannel_adc_sample_unpacker_top.
module masu_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [4:0]  out_active_channel,
  input logic        out_trigger_hit,
  input logic [13:0] out_sample_value
);
  import masu_pkg::*;

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // The input stalls only behind a stalled, held sample.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a stalled output");

  // A new sample only follows an accepted byte.
  a_sample_source: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !$past(out_valid && out_stall)) |-> $past(in_valid && !in_stall))
    else $error("sample appeared without an accepted byte");

  // Only the first compacted channels can trigger.
  a_trig_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_trigger_hit) |-> (out_active_channel < 5'(TRIGGER_CHANNELS)))
    else $error("trigger on a channel without a level");

  // A stalled sample holds its value.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_sample_value)))
    else $error("stalled sample changed");

endmodule

bind multichannel_adc_sample_unpacker_top masu_checker u_masu_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_valid),
  .in_stall           (in_stall),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_active_channel (out_active_channel),
  .out_trigger_hit    (out_trigger_hit),
  .out_sample_value   (out_sample_value)
);

### sim/tb.sv
// Testbench for the multichannel ADC sample unpacker: drives payload words, writes the
// registers over the configuration port and checks every sample word against a predictor.
// Depends on masu_pkg and multichannel_adc_sample_unpacker_top.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import masu_pkg::*;

  localparam int CLK_HALF     = 4;
  localparam int RESET_CYCLES = 11;
  localparam int SETTLE       = 4;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int REPORT_MAX   = 10;

  // Codes that the package leaves unnamed; both act as their neighbors.
  localparam logic [1:0] WMODE_UNUSED = 2'd3;
  localparam logic [1:0] TRIG_UNUSED  = 2'd3;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  logic [7:0]            in_payload_byte;
  logic                  out_valid;
  logic                  out_stall;
  logic [13:0]           out_sample_value;
  logic [4:0]            out_physical_channel;
  logic [4:0]            out_active_channel;
  logic                  out_trigger_hit;
  logic [31:0]           out_block_number;
  logic                  out_last_in_block;
  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  logic gaps_on  = 1'b1;
  logic stall_on = 1'b1;

  // Predicted sample words, oldest first.
  result_t expected_samples[$];
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;

  // Register contents and unpacking state as the predictor sees them.
  cfg_t        cur_cfg;
  int unsigned bit_acc       = 0;
  int unsigned bits_held     = 0;
  int unsigned group_pos     = 0;
  int unsigned chan_in_group = 0;
  int unsigned comp_count    = 0;
  int unsigned byte_count    = 0;
  logic [31:0] blocks_done   = '0;

  multichannel_adc_sample_unpacker_top dut (.*);

  always #CLK_HALF clk = ~clk;

  // First enabled channel slot at or after s, or SLOT_TOTAL when none is left.
  function automatic int unsigned next_slot_from(input int unsigned s);
    while (s < SLOT_TOTAL && !(s < 32 && cur_cfg.enabled[s])) s++;
    return s;
  endfunction

  // Level trigger for one sample of a compacted channel.
  function automatic logic level_trigger(input int unsigned idx, input logic [13:0] value);
    logic [1:0]        mode;
    logic signed [15:0] level;
    int                v;
    if (!cur_cfg.armed || idx >= TRIGGER_CHANNELS || idx >= 8) return 1'b0;
    mode = cur_cfg.modes[2*idx +: 2];
    if (idx < 4) level = cur_cfg.levels_lo[16*idx +: 16];
    else level = cur_cfg.levels_hi[16*(idx-4) +: 16];
    v = int'(value);
    if (mode == TRIG_OFF) return 1'b0;
    if (mode == TRIG_ABOVE) return int'(level) < v;
    return int'(level) > v;
  endfunction

  // Advance the unpacking state by one payload word and queue any sample it completes.
  function automatic void unpack_byte(input logic [7:0] b);
    int unsigned w;
    int unsigned slot;
    int unsigned nxt;
    int unsigned plen;
    result_t     r;
    case (cur_cfg.width_mode)
      WMODE_8:  w = 8;
      WMODE_12: w = 12;
      default:  w = 14;
    endcase
    if (group_pos >= GROUP_COUNT) slot = SLOT_TOTAL;
    else slot = next_slot_from(group_pos * CHANNELS_PER_GROUP + chan_in_group);

    if (slot < SLOT_TOTAL) begin
      if (bits_held > 16) bits_held = 16;
      bit_acc = ((bit_acc << 8) | b) & 32'h00FF_FFFF;
      bits_held += 8;
      if (bits_held >= w) begin
        r.sample_value = 14'((bit_acc >> (bits_held - w)) & ((1 << w) - 1));
        nxt = next_slot_from(slot + 1);
        r.last_in_block = (nxt >= SLOT_TOTAL);
        bits_held -= w;
        // A group ends on a byte boundary, so leftover bits are dropped.
        if (r.last_in_block || nxt / CHANNELS_PER_GROUP != slot / CHANNELS_PER_GROUP)
          bits_held = 0;
        r.physical_channel = 5'(slot);
        r.active_channel   = 5'(comp_count);
        r.trigger_hit      = level_trigger(comp_count, r.sample_value);
        r.block_number     = blocks_done;
        expected_samples.push_back(r);
        if (comp_count < COMP_MAX) comp_count++;
        slot = nxt;
      end
    end

    if (slot >= SLOT_TOTAL) begin
      group_pos = GROUP_COUNT;
      chan_in_group = 0;
      bits_held = 0;
    end else begin
      group_pos = slot / CHANNELS_PER_GROUP;
      chan_in_group = slot % CHANNELS_PER_GROUP;
    end

    // The block closes once its content is done and the padding is consumed.
    if (byte_count < 32'hFFFF) byte_count++;
    if (cur_cfg.padded == 0) plen = PAD_MIN;
    else if (cur_cfg.padded > PAD_MAX) plen = PAD_MAX;
    else plen = cur_cfg.padded;
    if (slot >= SLOT_TOTAL && byte_count >= plen) begin
      blocks_done++;
      byte_count = 0;
      group_pos = 0;
      chan_in_group = 0;
      bit_acc = 0;
      bits_held = 0;
      comp_count = 0;
    end
  endfunction

  // Send one payload word, with an occasional idle burst in front of it.
  task automatic send_byte(input logic [7:0] b);
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_payload_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    unpack_byte(b);
  endtask

  // Hold off the sender until every predicted sample has come out.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_samples.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // One register write: setup cycle, then access cycle until pready.
  task automatic write_reg(input reg_idx_t idx, input logic [63:0] val);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= CFG_ADDR_W'(8 * int'(idx));
    cfg_pwdata  <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
  endtask

  // Write all registers; only called while the block is idle.
  task automatic load_config(input cfg_t c);
    write_reg(REG_WIDTH_MODE, 64'(c.width_mode));
    write_reg(REG_ENABLED,    64'(c.enabled));
    write_reg(REG_PADDED,     64'(c.padded));
    write_reg(REG_TRIG_ARMED, 64'(c.armed));
    write_reg(REG_TRIG_MODES, 64'(c.modes));
    write_reg(REG_LEVELS_LO,  c.levels_lo);
    write_reg(REG_LEVELS_HI,  c.levels_hi);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cur_cfg = c;
  endtask

  // Two channels at opposite ends of the mask, 8-bit samples, zero padding length.
  task automatic test_extremes();
    cfg_t       c;
    logic [7:0] pattern [4] = '{8'h00, 8'hFF, 8'hFF, 8'h00};
    wait_idle();
    c = '0;
    c.width_mode = WMODE_8;
    c.enabled    = 32'h8000_0001;
    c.padded     = 7'd0;
    c.armed      = 1'b1;
    c.modes      = {12'd0, TRIG_BELOW, TRIG_ABOVE};
    c.levels_lo  = {32'd0, 16'h8000, 16'h007F};
    load_config(c);
    foreach (pattern[i]) send_byte(pattern[i]);
  endtask

  // 12-bit samples with trailing padding, then the unused width code.
  task automatic test_width_modes();
    cfg_t       c;
    logic [7:0] pattern [4] = '{8'hA5, 8'h5A, 8'hC3, 8'hFF};
    wait_idle();
    c = '0;
    c.width_mode = WMODE_12;
    c.enabled    = 32'h0000_0003;
    c.padded     = 7'd4;
    load_config(c);
    foreach (pattern[i]) send_byte(pattern[i]);
    wait_idle();
    c.width_mode = WMODE_UNUSED;
    load_config(c);
    foreach (pattern[i]) send_byte(~pattern[i]);
  endtask

  // Blocks with no channels still count, as the next block number shows.
  task automatic test_empty_mask();
    cfg_t c;
    wait_idle();
    c = '0;
    c.width_mode = WMODE_8;
    c.enabled    = 32'h0;
    c.padded     = 7'd2;
    load_config(c);
    repeat (4) send_byte(8'($urandom_range(0, 255)));
    wait_idle();
    c.enabled = 32'h0000_0100;
    c.padded  = 7'd1;
    load_config(c);
    send_byte(8'h5C);
  endtask

  // Every trigger code, extreme levels, and a compacted index past the trigger channels.
  task automatic test_trigger();
    cfg_t       c;
    logic [7:0] pattern [9] = '{8'h00, 8'hFF, 8'h40, 8'h41, 8'h3F,
                                8'h80, 8'h81, 8'hFF, 8'hFE};
    wait_idle();
    c = '0;
    c.width_mode = WMODE_8;
    c.enabled    = 32'h0000_01FF;
    c.padded     = 7'd9;
    c.armed      = 1'b1;
    c.modes      = {TRIG_ABOVE, TRIG_ABOVE, TRIG_BELOW, TRIG_UNUSED,
                    TRIG_OFF, TRIG_ABOVE, TRIG_BELOW, TRIG_UNUSED};
    c.levels_lo  = {16'h0000, 16'h0040, 16'h8000, 16'h7FFF};
    c.levels_hi  = {16'h00FF, 16'h0080, 16'h0000, 16'hFFFF};
    load_config(c);
    foreach (pattern[i]) send_byte(pattern[i]);
  endtask

  // Pick a random register set, biased toward padding that matches the content.
  task automatic random_config();
    cfg_t        c;
    int unsigned w;
    int unsigned content;
    logic [15:0] lvl;
    c = '0;
    c.width_mode = 2'($urandom_range(0, 3));
    case ($urandom_range(0, 5))
      0:       c.enabled = '1;
      1:       c.enabled = '0;
      2:       c.enabled = 32'd1 << $urandom_range(0, 31);
      3:       c.enabled = $urandom & $urandom;
      4:       c.enabled = 32'hFF << (8 * $urandom_range(0, 3));
      default: c.enabled = $urandom;
    endcase
    case (c.width_mode)
      WMODE_8:  w = 8;
      WMODE_12: w = 12;
      default:  w = 14;
    endcase
    content = 0;
    for (int g = 0; g < GROUP_COUNT; g++)
      content += ($countones(c.enabled[g*CHANNELS_PER_GROUP +: CHANNELS_PER_GROUP]) * w + 7) / 8;
    if ($urandom_range(0, 3) == 0) c.padded = 7'($urandom_range(0, 127));
    else c.padded = 7'(content + $urandom_range(0, 3));
    c.armed = 1'($urandom_range(0, 1));
    c.modes = 16'($urandom);
    for (int k = 0; k < TRIGGER_CHANNELS; k++) begin
      case ($urandom_range(0, 2))
        0:       lvl = 16'($urandom_range(0, 255));
        1:       lvl = 16'($urandom_range(0, 16383));
        default: lvl = 16'($urandom);
      endcase
      if (k < 4) c.levels_lo[16*k +: 16] = lvl;
      else c.levels_hi[16*(k-4) +: 16] = lvl;
    end
    load_config(c);
  endtask

  // Phases of random payload words; a phase often ends mid-block, so the next
  // register set takes effect without realignment.
  task automatic test_random_traffic(input int unsigned item_goal, input logic with_idling);
    int unsigned sent;
    int unsigned len;
    sent = 0;
    while (sent < item_goal) begin
      wait_idle();
      random_config();
      gaps_on  = with_idling && ($urandom_range(0, 3) != 0);
      stall_on = with_idling && ($urandom_range(0, 3) != 0);
      len = $urandom_range(8, 90);
      repeat (len) send_byte(8'($urandom_range(0, 255)));
      sent += len;
    end
  endtask

  // Random stall bursts on the result side.
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_on && $urandom_range(0, 4) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 10)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Compare each accepted sample word with the oldest prediction.
  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_samples.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX)
          $display("%0t: sample word with none predicted: val=%h phys=%0d act=%0d",
                   $time, out_sample_value, out_physical_channel, out_active_channel);
      end else begin
        want = expected_samples.pop_front();
        if (want.sample_value !== out_sample_value ||
            want.physical_channel !== out_physical_channel ||
            want.active_channel !== out_active_channel ||
            want.trigger_hit !== out_trigger_hit ||
            want.block_number !== out_block_number ||
            want.last_in_block !== out_last_in_block) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_MAX)
            $display({"%0t: sample error: exp val=%h phys=%0d act=%0d trig=%b blk=%0d ",
                      "last=%b, got val=%h phys=%0d act=%0d trig=%b blk=%0d last=%b"},
                     $time, want.sample_value, want.physical_channel,
                     want.active_channel, want.trigger_hit, want.block_number,
                     want.last_in_block, out_sample_value, out_physical_channel,
                     out_active_channel, out_trigger_hit, out_block_number,
                     out_last_in_block);
        end
      end
    end
  end

  // Watchdog on the whole run.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Mismatches found");
    $finish;
  end

  // Reset, then the tests in turn.
  initial begin
    rst_n           <= 1'b0;
    in_valid        <= 1'b0;
    in_payload_byte <= 8'h00;
    cfg_psel        <= 1'b0;
    cfg_penable     <= 1'b0;
    cfg_pwrite      <= 1'b0;
    cfg_paddr       <= '0;
    cfg_pwdata      <= '0;
    cur_cfg            = '0;
    cur_cfg.width_mode = WMODE_14;
    cur_cfg.enabled    = '1;
    cur_cfg.padded     = 7'd56;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_extremes();
    test_width_modes();
    test_empty_mask();
    test_trigger();
    test_random_traffic(640, 1'b1);
    test_random_traffic(110, 1'b0);

    wait_idle();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0 && expected_samples.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
